### hw/rtl/bcfs_pkg.sv
// Shared types, constants and arithmetic helpers for the back-face cull and flat shade block.
package bcfs_pkg;

    // Register index decode
    localparam logic [1:0] RegCameraX = 2'd0;
    localparam logic [1:0] RegCameraY = 2'd1;
    localparam logic [1:0] RegCameraZ = 2'd2;

    // Vector normalization target: largest magnitude lands in [2^28, 2^29)
    localparam logic [6:0] NormBits = 7'd29;

    // Shading factor in Q16: 0.7 + 0.3 * |cos|
    localparam logic [16:0] FactorBase  = 17'd45875;
    localparam logic [14:0] FactorSlope = 15'd19661;
    localparam logic [16:0] CosOne      = 17'd65536;

    // Quotient bits produced by the divider
    localparam logic [4:0] DivQTop = 5'd16;
    localparam logic [4:0] DivSat  = 5'd17;

    // Square root stage state: remaining radicand bits, partial remainder, partial root
    typedef struct packed {
        logic [59:0] x;
        logic [31:0] rem;
        logic [29:0] root;
    } sq_t;

    // Divider stage state
    typedef struct packed {
        logic [61:0] rem;
        logic [43:0] den;
        logic [16:0] q;
        logic        sat;
    } dv_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? unsigned'(-v) : unsigned'(v);
    endfunction

    // Bit length of the largest component magnitude
    function automatic logic [6:0] norm_len(input logic signed [63:0] v0,
                                            input logic signed [63:0] v1,
                                            input logic signed [63:0] v2);
        logic [63:0] m;
        logic [6:0]  bl;
        m  = mag64(v0) | mag64(v1) | mag64(v2);
        bl = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (m[k])
            begin
                bl = 7'(k + 1);
            end
        end
        return bl;
    endfunction

    // Floor shift right or shift left so the largest magnitude has NormBits bits
    function automatic logic signed [29:0] norm_apply(input logic signed [63:0] v,
                                                      input logic [6:0] bl);
        logic signed [63:0] r;
        if (bl > NormBits)
        begin
            r = v >>> (bl - NormBits);
        end
        else
        begin
            r = v <<< (NormBits - bl);
        end
        return r[29:0];
    endfunction

    function automatic logic signed [59:0] smul30(input logic signed [29:0] a,
                                                  input logic signed [29:0] b);
        return 60'(a) * 60'(b);
    endfunction

    // Two digit steps of the restoring square root
    function automatic sq_t sq_stage(input sq_t s);
        sq_t         r;
        logic [33:0] t;
        logic [31:0] trial;
        r = s;
        for (int k = 0; k < 2; k++)
        begin
            t     = {r.rem, r.x[59:58]};
            r.x   = {r.x[57:0], 2'b00};
            trial = {r.root, 2'b01};
            if (t >= 34'(trial))
            begin
                r.rem  = 32'(t - 34'(trial));
                r.root = {r.root[28:0], 1'b1};
            end
            else
            begin
                r.rem  = t[31:0];
                r.root = {r.root[28:0], 1'b0};
            end
        end
        return r;
    endfunction

    // One restoring division step for quotient bit i
    function automatic dv_t div_bit(input dv_t d, input logic [4:0] i);
        dv_t         r;
        logic [62:0] sh;
        r  = d;
        sh = 63'(d.den) << i;
        if (63'(d.rem) >= sh)
        begin
            r.rem  = 62'(63'(d.rem) - sh);
            r.q[i] = 1'b1;
        end
        return r;
    endfunction

endpackage

### hw/rtl/bcfs_if.sv
// Valid/ready channel interfaces for triangles in and shaded results out.
interface bcfs_tri_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;
    logic        [31:0]            base_rgba;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                    vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, base_rgba,
                    input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                  vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, base_rgba,
                  output ready);
endinterface

interface bcfs_shade_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [31:0] shaded_rgba;

    modport source (output valid, visible, shaded_rgba, input ready);
    modport sink (input valid, visible, shaded_rgba, output ready);
endinterface

### hw/rtl/backface_cull_flat_shade.sv
// Back-face cull and flat shade: 38-stage pipeline, one triangle per cycle when the output does not stall.
// Throughput: one triangle per cycle while the output is not stalled; each stage advances when it is empty or its
//   successor advances, so bubbles are squeezed out and stalls lose nothing.
// Reset (rst_n low, asynchronous): all stage valid bits clear, camera registers go to 0.
module backface_cull_flat_shade #(
    parameter int COORD_WIDTH = 32,
    localparam int DataW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int AddrW = (COORD_WIDTH > 32) ? 5 : 4
) (
    input  logic             clk,
    input  logic             rst_n,
    bcfs_tri_if.sink         triangle,
    bcfs_shade_if.source     shade,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);
    import bcfs_pkg::*;

    localparam int AddrLsb = (COORD_WIDTH > 32) ? 3 : 2;
    // Coordinates wider than 32 bits keep their top 32 bits (floor shift)
    localparam int CvtTop  = (COORD_WIDTH > 32) ? COORD_WIDTH - 1 : 31;
    localparam int NST     = 38;

    // Stage map:
    //   0      edge vectors e1, e2 and scaled centroid direction s
    //   1,2    normalize e1, e2, s (length search, then shift)
    //   3,4    cross product (multiply, then subtract)
    //   5,6    normalize n
    //   7,8    dot products n.s, n.n, s.s
    //   9..23  two square roots, two root bits per stage
    //   24     denominator (|n| * |s|) >> 16
    //   25..33 divider |d| / den, saturate check then two quotient bits per stage
    //   34..36 shading factor and channel products
    //   37     output register

    // ---------------------------------------------------------------- config
    logic [COORD_WIDTH-1:0] cam_x_reg;
    logic [COORD_WIDTH-1:0] cam_y_reg;
    logic [COORD_WIDTH-1:0] cam_z_reg;
    logic [1:0]             reg_idx;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[AddrW-1:AddrLsb];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                RegCameraX: cam_x_reg <= pwdata[COORD_WIDTH-1:0];
                RegCameraY: cam_y_reg <= pwdata[COORD_WIDTH-1:0];
                RegCameraZ: cam_z_reg <= pwdata[COORD_WIDTH-1:0];
                default:    ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            RegCameraX: prdata = DataW'(cam_x_reg);
            RegCameraY: prdata = DataW'(cam_y_reg);
            RegCameraZ: prdata = DataW'(cam_z_reg);
            default:    prdata = '0;
        endcase
    end

    // Sign-extend and bring a coordinate to 32 significant bits
    function automatic logic signed [31:0] to_q(input logic [COORD_WIDTH-1:0] raw);
        logic signed [COORD_WIDTH+31:0] wide;
        wide = (COORD_WIDTH + 32)'(signed'(raw));
        return wide[CvtTop -: 32];
    endfunction

    // ------------------------------------------------------- stage control
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] adv;

    // A stage advances if it or any stage after it is empty, or the sink takes the result
    for (genvar i = 0; i < NST; i++)
    begin : g_adv
        assign adv[i] = shade.ready || !(&valid_reg[NST-1:i]);
    end

    assign triangle.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= triangle.valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // --------------------------------------------------------- stage 0
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] vc [3];
    logic signed [34:0] cam3 [3];

    assign va[0] = to_q(triangle.vertex_a_x);
    assign va[1] = to_q(triangle.vertex_a_y);
    assign va[2] = to_q(triangle.vertex_a_z);
    assign vb[0] = to_q(triangle.vertex_b_x);
    assign vb[1] = to_q(triangle.vertex_b_y);
    assign vb[2] = to_q(triangle.vertex_b_z);
    assign vc[0] = to_q(triangle.vertex_c_x);
    assign vc[1] = to_q(triangle.vertex_c_y);
    assign vc[2] = to_q(triangle.vertex_c_z);

    // Three times the camera position; the direction is 3x camera-to-centroid
    assign cam3[0] = 35'(to_q(cam_x_reg)) + (35'(to_q(cam_x_reg)) <<< 1);
    assign cam3[1] = 35'(to_q(cam_y_reg)) + (35'(to_q(cam_y_reg)) <<< 1);
    assign cam3[2] = 35'(to_q(cam_z_reg)) + (35'(to_q(cam_z_reg)) <<< 1);

    logic signed [32:0] e1_0_reg [3];
    logic signed [32:0] e2_0_reg [3];
    logic signed [34:0] s_0_reg  [3];
    logic [31:0]        rgba_reg [0:36];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_0_reg[i] <= 33'(vb[i]) - 33'(va[i]);
                e2_0_reg[i] <= 33'(vc[i]) - 33'(va[i]);
                s_0_reg[i]  <= 35'(va[i]) + 35'(vb[i]) + 35'(vc[i]) - cam3[i];
            end
            rgba_reg[0] <= triangle.base_rgba;
        end
    end

    // Carry the base color down to the output stage
    for (genvar i = 1; i <= 36; i++)
    begin : g_rgba
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                rgba_reg[i] <= rgba_reg[i-1];
            end
        end
    end

    // ----------------------------------------------- stages 1-2: normalize
    logic signed [32:0] e1_1_reg [3];
    logic signed [32:0] e2_1_reg [3];
    logic signed [34:0] s_1_reg  [3];
    logic [6:0]         bl_e1_reg;
    logic [6:0]         bl_e2_reg;
    logic [6:0]         bl_s_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            e1_1_reg  <= e1_0_reg;
            e2_1_reg  <= e2_0_reg;
            s_1_reg   <= s_0_reg;
            bl_e1_reg <= norm_len(64'(e1_0_reg[0]), 64'(e1_0_reg[1]), 64'(e1_0_reg[2]));
            bl_e2_reg <= norm_len(64'(e2_0_reg[0]), 64'(e2_0_reg[1]), 64'(e2_0_reg[2]));
            bl_s_reg  <= norm_len(64'(s_0_reg[0]), 64'(s_0_reg[1]), 64'(s_0_reg[2]));
        end
    end

    logic signed [29:0] e1n_reg [3];
    logic signed [29:0] e2n_reg [3];
    logic signed [29:0] sn_reg  [2:6][3];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1n_reg[i]   <= norm_apply(64'(e1_1_reg[i]), bl_e1_reg);
                e2n_reg[i]   <= norm_apply(64'(e2_1_reg[i]), bl_e2_reg);
                sn_reg[2][i] <= norm_apply(64'(s_1_reg[i]), bl_s_reg);
            end
        end
    end

    // Hold the normalized direction until the dot products
    for (genvar i = 3; i <= 6; i++)
    begin : g_sn
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                sn_reg[i] <= sn_reg[i-1];
            end
        end
    end

    // --------------------------------------------- stages 3-4: cross product
    logic signed [59:0] cp_reg [6];
    logic signed [60:0] n_4_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            cp_reg[0] <= smul30(e1n_reg[1], e2n_reg[2]);
            cp_reg[1] <= smul30(e1n_reg[2], e2n_reg[1]);
            cp_reg[2] <= smul30(e1n_reg[2], e2n_reg[0]);
            cp_reg[3] <= smul30(e1n_reg[0], e2n_reg[2]);
            cp_reg[4] <= smul30(e1n_reg[0], e2n_reg[1]);
            cp_reg[5] <= smul30(e1n_reg[1], e2n_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_4_reg[i] <= 61'(cp_reg[2*i]) - 61'(cp_reg[2*i+1]);
            end
        end
    end

    // -------------------------------------------- stages 5-6: normalize n
    logic signed [60:0] n_5_reg [3];
    logic [6:0]         bl_n_reg;
    logic signed [29:0] nn_reg  [3];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            n_5_reg  <= n_4_reg;
            bl_n_reg <= norm_len(64'(n_4_reg[0]), 64'(n_4_reg[1]), 64'(n_4_reg[2]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                nn_reg[i] <= norm_apply(64'(n_5_reg[i]), bl_n_reg);
            end
        end
    end

    // ------------------------------------------ stages 7-8: dot products
    logic signed [59:0] pd_reg [3];
    logic signed [59:0] pn_reg [3];
    logic signed [59:0] ps_reg [3];
    logic signed [61:0] d_reg;
    logic signed [61:0] nsq_sum;
    logic signed [61:0] ssq_sum;
    logic [59:0]        nsq_reg;
    logic [59:0]        ssq_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= smul30(nn_reg[i], sn_reg[6][i]);
                pn_reg[i] <= smul30(nn_reg[i], nn_reg[i]);
                ps_reg[i] <= smul30(sn_reg[6][i], sn_reg[6][i]);
            end
        end
    end

    assign nsq_sum = 62'(pn_reg[0]) + 62'(pn_reg[1]) + 62'(pn_reg[2]);
    assign ssq_sum = 62'(ps_reg[0]) + 62'(ps_reg[1]) + 62'(ps_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            d_reg   <= 62'(pd_reg[0]) + 62'(pd_reg[1]) + 62'(pd_reg[2]);
            nsq_reg <= nsq_sum[59:0];
            ssq_reg <= ssq_sum[59:0];
        end
    end

    // --------------------------------------- stages 9-23: square roots
    logic        cull_reg  [9:36];
    logic        dzero_reg [9:33];
    logic [61:0] dmag_reg  [9:24];
    sq_t         sqn_reg   [15];
    sq_t         sqs_reg   [15];

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            // A positive dot faces away: cull
            cull_reg[9]  <= !d_reg[61] && (d_reg != '0);
            dzero_reg[9] <= (d_reg == '0);
            dmag_reg[9]  <= d_reg[61] ? unsigned'(-d_reg) : unsigned'(d_reg);
        end
    end

    for (genvar i = 10; i <= 36; i++)
    begin : g_cull
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                cull_reg[i] <= cull_reg[i-1];
            end
        end
    end

    for (genvar i = 10; i <= 33; i++)
    begin : g_dzero
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                dzero_reg[i] <= dzero_reg[i-1];
            end
        end
    end

    for (genvar i = 10; i <= 24; i++)
    begin : g_dmag
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                dmag_reg[i] <= dmag_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 15; k++)
    begin : g_sqrt
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv[9])
                begin
                    sqn_reg[0] <= sq_stage('{x: nsq_reg, rem: '0, root: '0});
                    sqs_reg[0] <= sq_stage('{x: ssq_reg, rem: '0, root: '0});
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (adv[9+k])
                begin
                    sqn_reg[k] <= sq_stage(sqn_reg[k-1]);
                    sqs_reg[k] <= sq_stage(sqs_reg[k-1]);
                end
            end
        end
    end

    // ------------------------------------------- stage 24: denominator
    logic [59:0] rr_prod;
    logic [43:0] den_reg;

    assign rr_prod = 60'(sqn_reg[14].root) * 60'(sqs_reg[14].root);

    always_ff @(posedge clk)
    begin
        if (adv[24])
        begin
            den_reg <= rr_prod[59:16];
        end
    end

    // --------------------------------------------- stages 25-33: divider
    dv_t dv_reg [9];

    for (genvar j = 0; j < 9; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            dv_t dv_init;
            always_comb
            begin
                dv_init     = '{rem: dmag_reg[24], den: den_reg, q: '0, sat: 1'b0};
                // Quotient at or above 2^17 clamps to one anyway
                dv_init.sat = 63'(dmag_reg[24]) >= (63'(den_reg) << DivSat);
            end
            always_ff @(posedge clk)
            begin
                if (adv[25])
                begin
                    dv_reg[0] <= div_bit(dv_init, DivQTop);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (adv[25+j])
                begin
                    dv_reg[j] <= div_bit(div_bit(dv_reg[j-1], 5'(17 - 2*j)), 5'(16 - 2*j));
                end
            end
        end
    end

    // ---------------------------------------------- stages 34-36: shading
    logic [16:0] cosq;
    logic [31:0] fprod_reg;
    logic [16:0] f_reg;
    logic [24:0] chp_reg [3];

    always_comb
    begin
        if (dzero_reg[33])
        begin
            cosq = '0;
        end
        else if (dv_reg[8].sat || (dv_reg[8].q > CosOne))
        begin
            cosq = CosOne;
        end
        else
        begin
            cosq = dv_reg[8].q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[34])
        begin
            fprod_reg <= 32'(cosq) * 32'(FactorSlope);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[35])
        begin
            f_reg <= FactorBase + 17'(fprod_reg[31:16]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[36])
        begin
            for (int i = 0; i < 3; i++)
            begin
                chp_reg[i] <= 25'(rgba_reg[35][8*(i+1) +: 8]) * 25'(f_reg);
            end
        end
    end

    // ---------------------------------------------------- stage 37: output
    logic [7:0]  chan [3];
    logic        vis_reg;
    logic [31:0] out_rgba_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            chan[i] = (chp_reg[i][24]) ? 8'hff : chp_reg[i][23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[37])
        begin
            vis_reg      <= !cull_reg[36];
            out_rgba_reg <= cull_reg[36] ? '0 : {chan[2], chan[1], chan[0], rgba_reg[36][7:0]};
        end
    end

    assign shade.valid       = valid_reg[NST-1];
    assign shade.visible     = vis_reg;
    assign shade.shaded_rgba = out_rgba_reg;

endmodule

### hw/rtl/bcfs_checker.sv
// Port-level checker for the back-face cull and flat shade block, bound to the top level.
module bcfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        visible,
    input logic [31:0] shaded_rgba
);

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(shaded_rgba))
        else $error("result changed while stalled");

    // A culled face carries no color
    a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> shaded_rgba == 32'd0)
        else $error("culled result has nonzero color");

    // With the output slot empty the pipeline can always take a triangle
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output slot");

    // A result transfer frees a slot for the input in the same cycle
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled during result transfer");

endmodule

bind backface_cull_flat_shade bcfs_checker u_bcfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (triangle.ready),
    .out_valid   (shade.valid),
    .out_ready   (shade.ready),
    .visible     (shade.visible),
    .shaded_rgba (shade.shaded_rgba)
);

### dv/tb_top.sv
// Self-checking bench for the back-face cull and flat shade pipeline.
module tb_top;
    import bcfs_pkg::*;

    typedef struct {
        logic signed [31:0] vx [9];
        logic [31:0]        rgba;
    } triangle_t;

    typedef struct {
        logic        visible;
        logic [31:0] rgba;
    } shade_t;

    // Expected-shade store plus a fixed-point model of the face test.
    class shade_scoreboard;
        shade_t          pending[$];
        longint          camera[3];
        int              mismatches;
        int              failures;

        function void set_camera(int idx, logic [31:0] value);
            camera[idx] = longint'(signed'(value));
        endfunction

        function void renorm(ref longint v[3]);
            longint unsigned m;
            longint unsigned a;
            int              k;
            m = 0;
            k = 0;
            for (int i = 0; i < 3; i++)
            begin
                a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
                if (a > m)
                begin
                    m = a;
                end
            end
            if (m == 0)
            begin
                return;
            end
            if (m >= 64'd1 << 29)
            begin
                while ((m >> k) >= 64'd1 << 29)
                begin
                    k++;
                end
                for (int i = 0; i < 3; i++)
                begin
                    v[i] = v[i] >>> k;
                end
            end
            else
            begin
                while (m < 64'd1 << 28)
                begin
                    m = m << 1;
                    k++;
                end
                for (int i = 0; i < 3; i++)
                begin
                    v[i] = v[i] <<< k;
                end
            end
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
            begin
                b = b >> 2;
            end
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function shade_t predict_shade(triangle_t t);
            shade_t          res;
            longint          a[3], b[3], c[3], e1[3], e2[3], n[3], s[3];
            longint          d;
            longint unsigned q, f, rn, rs, den, ch, sc;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = longint'(t.vx[i]);
                b[i] = longint'(t.vx[3 + i]);
                c[i] = longint'(t.vx[6 + i]);
                e1[i] = b[i] - a[i];
                e2[i] = c[i] - a[i];
                s[i] = a[i] + b[i] + c[i] - 3 * camera[i];
            end
            renorm(e1);
            renorm(e2);
            n[0] = e1[1] * e2[2] - e1[2] * e2[1];
            n[1] = e1[2] * e2[0] - e1[0] * e2[2];
            n[2] = e1[0] * e2[1] - e1[1] * e2[0];
            renorm(n);
            renorm(s);
            d = n[0] * s[0] + n[1] * s[1] + n[2] * s[2];
            if (d > 0)
            begin
                res.visible = 1'b0;
                res.rgba = '0;
                return res;
            end
            q = 0;
            if (d != 0)
            begin
                rn = floor_sqrt(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
                rs = floor_sqrt(s[0] * s[0] + s[1] * s[1] + s[2] * s[2]);
                den = (rn * rs) >> 16;
                if (den != 0)
                begin
                    q = longint'(-d) / den;
                end
                if (q > 65536)
                begin
                    q = 65536;
                end
            end
            f = 64'(FactorBase) + ((64'(FactorSlope) * q) >> 16);
            res.visible = 1'b1;
            res.rgba = {24'h0, t.rgba[7:0]};
            for (int i = 1; i < 4; i++)
            begin
                ch = 64'((t.rgba >> (8 * i)) & 32'hFF);
                sc = (ch * f) >> 16;
                if (sc > 255)
                begin
                    sc = 255;
                end
                res.rgba[8 * i +: 8] = sc[7:0];
            end
            return res;
        endfunction

        function void note_triangle(triangle_t t);
            pending.insert(pending.size(), predict_shade(t));
        endfunction

        function void check_shade(logic visible, logic [31:0] rgba);
            shade_t want;
            if (pending.size() == 0)
            begin
                failures++;
                if (mismatches++ < 10)
                begin
                    $display("unexpected shade transfer: visible=%0b rgba=%08h", visible, rgba);
                end
                return;
            end
            want = pending.pop_front();
            if (want.visible !== visible || want.rgba !== rgba)
            begin
                failures++;
                if (mismatches++ < 10)
                begin
                    $display("shade mismatch: expected visible=%0b rgba=%08h, got %0b %08h",
                             want.visible, want.rgba, visible, rgba);
                end
            end
        endfunction
    endclass

    localparam int StallLimit = 20000;

    logic clk;
    logic rst_n;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    bcfs_tri_if #(.COORD_WIDTH(32)) triangle_ch ();
    bcfs_shade_if shade_ch ();

    backface_cull_flat_shade #(.COORD_WIDTH(32)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .triangle(triangle_ch),
        .shade   (shade_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    shade_scoreboard sb = new();

    // Idle percentages for each side; long_hold asks the receiver to hold off.
    int src_idle_pct;
    int sink_stall_pct;
    int long_hold;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    // Receiver: random stalls, plus a long hold-off counted down here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        shade_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                hold_left = long_hold;
                long_hold = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                shade_ch.ready <= 1'b0;
            end
            else
            begin
                shade_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Transfer monitor: note accepted triangles, check accepted shades.
    always @(posedge clk)
    begin
        triangle_t t;
        if (rst_n && triangle_ch.valid && triangle_ch.ready)
        begin
            t.vx[0] = triangle_ch.vertex_a_x;
            t.vx[1] = triangle_ch.vertex_a_y;
            t.vx[2] = triangle_ch.vertex_a_z;
            t.vx[3] = triangle_ch.vertex_b_x;
            t.vx[4] = triangle_ch.vertex_b_y;
            t.vx[5] = triangle_ch.vertex_b_z;
            t.vx[6] = triangle_ch.vertex_c_x;
            t.vx[7] = triangle_ch.vertex_c_y;
            t.vx[8] = triangle_ch.vertex_c_z;
            t.rgba  = triangle_ch.base_rgba;
            sb.note_triangle(t);
        end
        if (rst_n && shade_ch.valid && shade_ch.ready)
        begin
            sb.check_shade(shade_ch.visible, shade_ch.shaded_rgba);
        end
    end

    // Watchdog: drop the run if nothing transfers for too long.
    always @(posedge clk)
    begin
        if ((triangle_ch.valid && triangle_ch.ready) || (shade_ch.valid && shade_ch.ready)
            || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= StallLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one camera register through the setup and access phases.
    task automatic write_camera(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_camera(idx, value);
    endtask

    task automatic set_camera_all(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        write_camera(RegCameraX, x);
        write_camera(RegCameraY, y);
        write_camera(RegCameraZ, z);
    endtask

    // Offer one triangle until it transfers; valid stays high for back-to-back items.
    task automatic send_triangle(triangle_t t);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            triangle_ch.valid <= 1'b0;
            @(negedge clk);
        end
        triangle_ch.valid      <= 1'b1;
        triangle_ch.vertex_a_x <= t.vx[0];
        triangle_ch.vertex_a_y <= t.vx[1];
        triangle_ch.vertex_a_z <= t.vx[2];
        triangle_ch.vertex_b_x <= t.vx[3];
        triangle_ch.vertex_b_y <= t.vx[4];
        triangle_ch.vertex_b_z <= t.vx[5];
        triangle_ch.vertex_c_x <= t.vx[6];
        triangle_ch.vertex_c_y <= t.vx[7];
        triangle_ch.vertex_c_z <= t.vx[8];
        triangle_ch.base_rgba  <= t.rgba;
        @(posedge clk);
        while (!triangle_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted shade has come back.
    task automatic drain;
        @(negedge clk);
        triangle_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] small_coord();
        return 32'($urandom_range(0, 32'h3F_FFFF)) - 32'h20_0000;
    endfunction

    function automatic triangle_t make_triangle(logic [31:0] va, logic [31:0] vb,
                                                logic [31:0] vc, logic [31:0] rgba);
        triangle_t t;
        for (int i = 0; i < 9; i++)
        begin
            t.vx[i] = (i < 3) ? va : (i < 6) ? vb : vc;
        end
        t.rgba = rgba;
        return t;
    endfunction

    // Random triangle: mostly well-formed with varied scale, some degenerate or centered.
    function automatic triangle_t random_triangle();
        triangle_t t;
        int        kind;
        longint    cz;
        kind = $urandom_range(99);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 35)
            begin
                t.vx[i] = $urandom;
            end
            else
            begin
                t.vx[i] = small_coord() <<< $urandom_range(0, 9);
            end
        end
        if (kind >= 85 && kind < 92)
        begin
            // degenerate: two vertices coincide
            for (int i = 0; i < 3; i++)
            begin
                t.vx[6 + i] = t.vx[i];
            end
        end
        else if (kind >= 92)
        begin
            // centroid on the camera where it fits in range
            for (int i = 0; i < 3; i++)
            begin
                cz = 3 * sb.camera[i] - longint'(t.vx[i]) - longint'(t.vx[3 + i]);
                if (cz >= -(64'sd1 <<< 31) && cz < (64'sd1 <<< 31))
                begin
                    t.vx[6 + i] = cz[31:0];
                end
            end
        end
        t.rgba = $urandom;
        return t;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            send_triangle(random_triangle());
        end
        drain();
    endtask

    initial
    begin
        triangle_t t;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        triangle_ch.valid = 1'b0;
        triangle_ch.vertex_a_x = '0;
        triangle_ch.vertex_a_y = '0;
        triangle_ch.vertex_a_z = '0;
        triangle_ch.vertex_b_x = '0;
        triangle_ch.vertex_b_y = '0;
        triangle_ch.vertex_b_z = '0;
        triangle_ch.vertex_c_x = '0;
        triangle_ch.vertex_c_y = '0;
        triangle_ch.vertex_c_z = '0;
        triangle_ch.base_rgba = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        long_hold = 0;
        sb.camera = '{0, 0, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, both orientations, dot zero, degenerate, zero direction.
        send_triangle(make_triangle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_triangle(make_triangle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
        send_triangle(make_triangle(32'h0, 32'h0, 32'h0, 32'h1234_5678));
        t = make_triangle(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        t.vx[0] = 32'h1_0000;  t.vx[4] = 32'h1_0000;  t.vx[8] = 32'h1_0000;
        send_triangle(t);                       // normal along +(1,1,1): culled
        t.vx[3] = 32'h0;  t.vx[4] = 32'h0;  t.vx[5] = 32'h1_0000;
        t.vx[6] = 32'h0;  t.vx[7] = 32'h1_0000;  t.vx[8] = 32'h0;
        send_triangle(t);                       // reversed winding: visible
        t = make_triangle(32'h0, 32'h0, 32'h0, 32'h80FF_7F01);
        t.vx[0] = 32'h1_0000;  t.vx[4] = 32'h1_0000;
        t.vx[6] = 32'h1_0000;  t.vx[7] = 32'h1_0000;
        send_triangle(t);                       // camera in the plane: dot zero
        t = make_triangle(32'h0, 32'h0, 32'h0, 32'hA5A5_A5A5);
        t.vx[0] = 32'h1_0000;  t.vx[3] = 32'hFFFF_0000;  t.vx[4] = 32'h1_0000;
        t.vx[7] = 32'hFFFF_0000;  t.vx[2] = 32'h5;  t.vx[5] = 32'h3;  t.vx[8] = 32'hFFFF_FFF8;
        send_triangle(t);                       // centroid at the camera
        t.vx[6] = 32'h7FFF_FFFF;  t.vx[7] = 32'h8000_0000;  t.vx[8] = 32'h7FFF_FFFF;
        send_triangle(t);
        t = make_triangle(32'h0, 32'h0, 32'h0, 32'h0102_0304);
        t.vx[0] = 32'h7FFF_FFFF;  t.vx[6] = 32'h8000_0000;  t.vx[4] = 32'h8000_0000;
        send_triangle(t);
        t.vx[3] = t.vx[0];  t.vx[4] = t.vx[1];  t.vx[5] = t.vx[2];
        send_triangle(t);                       // coincident vertices: degenerate
        t.vx[2] = 32'h7FFF_FFFF;  t.vx[3] = 32'h8000_0001;  t.vx[7] = 32'h1;
        send_triangle(t);
        drain();

        // Phase with no idling at reset camera.
        random_phase(280);

        src_idle_pct = 82;
        set_camera_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_phase(280);

        src_idle_pct = 0;
        sink_stall_pct = 82;
        set_camera_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        random_phase(280);

        src_idle_pct = 32;
        sink_stall_pct = 32;
        set_camera_all($urandom, $urandom, $urandom);
        random_phase(280);

        // Fill the pipeline behind a long receiver hold-off.
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_camera_all(small_coord(), small_coord(), 32'h8000_0000);
        long_hold = 300;
        random_phase(280);

        repeat (60) @(posedge clk);
        if (sb.failures == 0 && sb.pending.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
